>>> hw/rtl/tpa_pkg.sv
// ---------------------------------------------------------------------------
// Trace pulse analyzer package
// Field widths, register indexes, fixed limits and small helper functions
// shared by the trace pulse analyzer.
// ---------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

	// Field widths of the input and result items.
	localparam int SAMPLE_W   = 12;
	localparam int BASE_W     = 13;
	localparam int CUR_W      = 14;
	localparam int DIFF_W     = 15;
	localparam int PEAKS_W    = 13;
	localparam int COUNT_W    = 14;
	localparam int HEIGHT_W   = 14;
	localparam int INTEG_W    = 24;
	localparam int INTEG_OUT_W = 25;
	localparam int CUT_W      = 13;

	// Stream data widths, padded to whole bytes.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 80;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int LEN_REG_W  = 13;
	localparam int THR_W      = 12;

	localparam logic [CFG_IDX_W-1:0] REG_TRACE_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_THRESHOLD = 2'd2;

	// Register reset values.
	localparam logic [LEN_REG_W-1:0] TRACE_LENGTH_RST    = 13'd2400;
	localparam logic [THR_W-1:0]     PEAK_THRESHOLD_RST  = 12'd20;
	localparam logic [THR_W-1:0]     PULSE_THRESHOLD_RST = 12'd25;

	// Marker for a trace without a baseline, at the widths where it appears.
	localparam logic signed [BASE_W-1:0]      NO_BASELINE      = -13'sd999;
	localparam logic signed [COUNT_W-1:0]     NO_BASELINE_14   = -14'sd999;
	localparam logic signed [INTEG_OUT_W-1:0] NO_BASELINE_25   = -25'sd999;

	// Saturation limits.
	localparam logic [INTEG_W-1:0] INTEGRAL_MAX = 24'hFF_FFFF;
	localparam logic [PEAKS_W-1:0] PEAKS_MAX    = 13'd8191;

	// Magnitude of a signed difference.
	function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	// Peak counter increment that holds at its ceiling.
	function automatic logic [PEAKS_W-1:0] peak_inc(input logic [PEAKS_W-1:0] p,
		input logic step);
		peak_inc = (step && (p < PEAKS_MAX)) ? PEAKS_W'(p + 1'b1) : p;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/trace_pulse_analyzer_unit.sv
// ---------------------------------------------------------------------------
// Trace pulse analyzer
// Per-trace pulse summary of a stream of baseline-tagged detector samples.
// ---------------------------------------------------------------------------
// Each slave transaction carries one 12-bit sample and the 13-bit signed
// baseline of its trace. Samples are counted into traces of trace_length
// samples (held to 1 .. MAX_TRACE). On the last sample of a trace one master
// transaction carries the summary: peak count, pulse height, saturated
// integral and the left and right cutoffs, or the no-baseline pattern when
// the last sample's baseline is -999. Other samples produce nothing.
// The configuration channel writes trace_length, peak_threshold and
// pulse_threshold by index; it is always ready and should be used only
// while no trace is in flight.
// Throughput is one sample per cycle unless a stalled summary blocks input:
// the sample sits in an input register while a short compare-and-add update
// of the trace state runs, and the summary goes on to the result register
// for the master side. The result register lets new samples in while a
// summary waits; only a second summary held behind a stalled one blocks the
// input. Reset returns the registers to their defaults and starts a fresh trace.
// ---------------------------------------------------------------------------
`default_nettype none

module trace_pulse_analyzer_unit #(
	parameter int MAX_TRACE     = 4096,
	parameter int CUTOFF_MARGIN = 20
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Slave stream.
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// Fields from bit 0: sample[11:0], baseline[24:12], zero padding.
	input  wire logic [tpa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// Master stream.
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// Fields from bit 0: peak_count[13:0], pulse_height[27:14],
	// pulse_integral[52:28], left_cutoff[65:53], right_cutoff[78:66], padding.
	output logic [tpa_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	// Configuration write channel.
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import tpa_pkg::*;

	localparam int IDX_W = $clog2(MAX_TRACE);
	localparam int LEN_W = $clog2(MAX_TRACE + 1);
	localparam int CW    = ((LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W) + 1;

	// Configuration registers.
	logic [LEN_REG_W-1:0] trace_length_q;
	logic [THR_W-1:0]     peak_threshold_q;
	logic [THR_W-1:0]     pulse_threshold_q;

	// Input register.
	logic                      valid_s1;
	logic [SAMPLE_W-1:0]       sample_s1;
	logic signed [BASE_W-1:0]  baseline_s1;

	// Trace state.
	logic [IDX_W-1:0]          sample_index_q;
	logic signed [CUR_W-1:0]   max_height_q;
	logic [INTEG_W-1:0]        integral_sum_q;
	logic signed [CUR_W-1:0]   local_low_q;
	logic signed [CUR_W-1:0]   local_high_q;
	logic [PEAKS_W-1:0]        peaks_seen_q;
	logic                      over_level_q;
	logic                      left_pending_q;
	logic                      right_pending_q;
	logic                      slope_rising_q;
	logic [CUT_W-1:0]          left_mark_q;
	logic [CUT_W-1:0]          right_mark_q;

	// Result register.
	logic                      out_valid_q;
	logic [OUT_DATA_W-1:0]     out_data_q;

	// Update logic signals.
	logic                      out_free;
	logic                      fire;
	logic                      last_sample;
	logic [CW-1:0]             len_reg_cw;
	logic [CW-1:0]             len_cw;
	logic [CW-1:0]             idx_cw;
	logic [CW-1:0]             margin_cw;
	logic signed [CUR_W-1:0]   cur;
	logic signed [DIFF_W-1:0]  cur15;
	logic signed [CUR_W-1:0]   low0;
	logic signed [DIFF_W-1:0]  low15;
	logic signed [DIFF_W-1:0]  high15;
	logic signed [DIFF_W-1:0]  peak_thr15;
	logic signed [DIFF_W-1:0]  pulse_thr15;
	logic [DIFF_W-1:0]         mag_cur;
	logic [DIFF_W-1:0]         mag_low;
	logic                      nearer_low;
	logic                      rise;
	logic                      higher;
	logic                      fall;
	logic                      over;
	logic                      end_peak;
	logic signed [DIFF_W:0]    tail_diff;
	logic [INTEG_OUT_W-1:0]    integ_sum;
	logic signed [CUR_W-1:0]   max_height_n;
	logic [INTEG_W-1:0]        integral_sum_n;
	logic signed [CUR_W-1:0]   local_low_n;
	logic signed [CUR_W-1:0]   local_high_n;
	logic [PEAKS_W-1:0]        peaks_seen_n;
	logic [PEAKS_W-1:0]        peaks_final;
	logic                      slope_rising_n;
	logic                      left_pending_n;
	logic                      right_pending_n;
	logic [CUT_W-1:0]          left_mark_n;
	logic [CUT_W-1:0]          right_mark_n;
	logic [CUT_W-1:0]          left_cut;
	logic [CUT_W-1:0]          right_cut;
	logic [OUT_DATA_W-1:0]     result;

	// Handshakes: the input register moves on unless a summary would land
	// on a result that is still waiting.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && (!last_sample || out_free);
	assign s_axis_tready = !valid_s1 || fire;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Effective trace length and end-of-trace detection.
	always_comb begin
		len_reg_cw = CW'(trace_length_q);
		if (len_reg_cw == '0) begin
			len_cw = CW'(1);
		end else if (len_reg_cw > CW'(MAX_TRACE)) begin
			len_cw = CW'(MAX_TRACE);
		end else begin
			len_cw = len_reg_cw;
		end
		idx_cw      = CW'(sample_index_q);
		margin_cw   = CW'(CUTOFF_MARGIN);
		last_sample = (idx_cw + CW'(1)) >= len_cw;
	end

	// Per-sample update of the trace state and the summary it would give.
	always_comb begin
		cur         = CUR_W'($signed({2'b00, sample_s1}))
		              - CUR_W'(baseline_s1);
		cur15       = DIFF_W'(cur);
		low0        = (sample_index_q == '0) ? cur : local_low_q;
		low15       = DIFF_W'(low0);
		high15      = DIFF_W'(local_high_q);
		peak_thr15  = $signed({3'b000, peak_threshold_q});
		pulse_thr15 = $signed({3'b000, pulse_threshold_q});
		mag_cur     = mag(cur15);
		mag_low     = mag(low15);

		// Hysteresis from the local low, then from the local high.
		nearer_low = mag_cur < mag_low;
		rise       = !nearer_low && (mag(cur15 - low15) > DIFF_W'(peak_thr15));
		higher     = mag_cur > mag(high15);
		fall       = slope_rising_q && !rise && !higher
		             && (mag(high15 - cur15) > DIFF_W'(peak_thr15));

		slope_rising_n = rise || (slope_rising_q && !fall);
		local_high_n   = (rise || (slope_rising_q && higher)) ? cur : local_high_q;
		local_low_n    = (nearer_low || fall) ? cur : low0;
		peaks_seen_n   = peak_inc(peaks_seen_q, fall);
		max_height_n   = (cur > max_height_q) ? cur : max_height_q;

		// Level crossing, integral and cutoff marks.
		over            = cur15 > pulse_thr15;
		integ_sum       = {1'b0, integral_sum_q} + INTEG_OUT_W'(cur[CUR_W-2:0]);
		integral_sum_n  = integral_sum_q;
		left_pending_n  = left_pending_q;
		right_pending_n = right_pending_q;
		left_mark_n     = left_mark_q;
		right_mark_n    = right_mark_q;
		if (over) begin
			integral_sum_n = (integ_sum > INTEG_OUT_W'(INTEGRAL_MAX)) ? INTEGRAL_MAX
			                 : integ_sum[INTEG_W-1:0];
			if (left_pending_q) begin
				left_mark_n    = (idx_cw <= margin_cw) ? '0 : CUT_W'(idx_cw - margin_cw);
				left_pending_n = 1'b0;
			end
		end else if (over_level_q) begin
			right_mark_n    = ((idx_cw + margin_cw) >= len_cw) ? CUT_W'(len_cw)
			                  : CUT_W'(idx_cw + margin_cw);
			right_pending_n = 1'b0;
		end

		// Closing of the trace.
		tail_diff   = $signed({1'b0, mag_cur}) - $signed({1'b0, mag(DIFF_W'(local_low_n))});
		end_peak    = slope_rising_n || (tail_diff > (DIFF_W + 1)'(peak_thr15));
		peaks_final = peak_inc(peaks_seen_n, end_peak);
		left_cut    = left_pending_n ? CUT_W'(len_cw) : left_mark_n;
		if (over) begin
			right_cut = CUT_W'(idx_cw);
		end else if (right_pending_n) begin
			right_cut = '0;
		end else begin
			right_cut = right_mark_n;
		end

		if (baseline_s1 == NO_BASELINE) begin
			result = {1'b0, CUT_W'(len_cw), CUT_W'(0), NO_BASELINE_25,
			          NO_BASELINE_14, NO_BASELINE_14};
		end else begin
			result = {1'b0, right_cut, left_cut, {1'b0, integral_sum_n},
			          HEIGHT_W'(max_height_n), {1'b0, peaks_final}};
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_length_q    <= TRACE_LENGTH_RST;
			peak_threshold_q  <= PEAK_THRESHOLD_RST;
			pulse_threshold_q <= PULSE_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TRACE_LENGTH:    trace_length_q    <= cfg_data;
				REG_PEAK_THRESHOLD:  peak_threshold_q  <= cfg_data[THR_W-1:0];
				REG_PULSE_THRESHOLD: pulse_threshold_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1   <= s_axis_tdata[SAMPLE_W-1:0];
			baseline_s1 <= s_axis_tdata[SAMPLE_W+BASE_W-1:SAMPLE_W];
		end
	end

	// Trace state; a finished trace clears everything for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q  <= '0;
			max_height_q    <= '0;
			integral_sum_q  <= '0;
			local_low_q     <= '0;
			local_high_q    <= '0;
			peaks_seen_q    <= '0;
			over_level_q    <= 1'b0;
			left_pending_q  <= 1'b1;
			right_pending_q <= 1'b1;
			slope_rising_q  <= 1'b0;
			left_mark_q     <= '0;
			right_mark_q    <= '0;
		end else if (fire) begin
			if (last_sample) begin
				sample_index_q  <= '0;
				max_height_q    <= '0;
				integral_sum_q  <= '0;
				local_low_q     <= '0;
				local_high_q    <= '0;
				peaks_seen_q    <= '0;
				over_level_q    <= 1'b0;
				left_pending_q  <= 1'b1;
				right_pending_q <= 1'b1;
				slope_rising_q  <= 1'b0;
				left_mark_q     <= '0;
				right_mark_q    <= '0;
			end else begin
				sample_index_q  <= IDX_W'(idx_cw + CW'(1));
				max_height_q    <= max_height_n;
				integral_sum_q  <= integral_sum_n;
				local_low_q     <= local_low_n;
				local_high_q    <= local_high_n;
				peaks_seen_q    <= peaks_seen_n;
				over_level_q    <= over;
				left_pending_q  <= left_pending_n;
				right_pending_q <= right_pending_n;
				slope_rising_q  <= slope_rising_n;
				left_mark_q     <= left_mark_n;
				right_mark_q    <= right_mark_n;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_sample) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire && last_sample) begin
			out_data_q <= result;
		end
	end

`ifndef SYNTHESIS
	// A level crossing always has set the left cutoff first.
	a_over_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		over_level_q |-> !left_pending_q)
		else $error("over_level set while left cutoff still pending");

	// A finished trace shows a result and restarts the sample count.
	a_summary_out: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_sample) |=> (m_axis_tvalid && (sample_index_q == '0)))
		else $error("summary not presented or sample index not restarted");

	// A waiting summary is never overwritten by the next one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !(fire && last_sample))
		else $error("stalled summary overwritten");
`endif

endmodule

`default_nettype wire
